/* rtl/bee_pkg.sv */
`default_nettype none

package bee_pkg;

	// Widths of the fixed-point words.
	localparam int unsigned CfgW = 24;
	localparam int unsigned AccW = 40;
	localparam int unsigned DivW = 64;
	localparam int unsigned DivCntW = $clog2(DivW);

	// Configuration register indexes.
	localparam logic [1:0] CFG_CHARGE_GAIN = 2'd0;
	localparam logic [1:0] CFG_QUENCH_FACTOR = 2'd1;
	localparam logic [1:0] CFG_ENERGY_CAP = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [CfgW-1:0] GAIN_RESET = 24'd50332;
	localparam logic [CfgW-1:0] QUENCH_RESET = 24'd11980;
	localparam logic [CfgW-1:0] CAP_RESET = 24'd256000;

	// Request codes.
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_HIT = 2'd1;
	localparam logic [1:0] REQ_END = 2'd2;
	localparam logic [1:0] REQ_REPORT = 2'd3;

	// Result kinds.
	localparam logic KIND_EVENT = 1'b0;
	localparam logic KIND_MEAN = 1'b1;

	// Datapath operations, one per cycle.
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LATCH,
		CMD_MUL_SUM,
		CMD_START_WR,
		CMD_MUL_A,
		CMD_MUL_B,
		CMD_DIV_R,
		CMD_DIV_Q,
		CMD_DIV_MSE,
		CMD_DIV_STEP,
		CMD_HIT_PLAIN,
		CMD_HIT_Q,
		CMD_MUL_SQ,
		CMD_END_OUT,
		CMD_REPORT_OUT
	} cmd_t;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_ST_MUL,
		S_ST_WR,
		S_H_MULA,
		S_H_MULB,
		S_H_CHK,
		S_H_DIVR,
		S_H_CHKR,
		S_H_DIVQ,
		S_H_ADD,
		S_E_MUL,
		S_E_OUT,
		S_R_CHK,
		S_R_DIV,
		S_R_OUT
	} state_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic dx_zero;
		logic div_last;
		logic r_big;
		logic cnt_zero;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

/* rtl/birks_energy_estimator.sv */
// Birks-corrected energy estimator. Words are taken one at a time and the
// input is ready only while the controller is idle; a waiting result word
// does not hold up the next input. An event end and a mean report wait until
// the output register is free. A hit with a zero path length skips the
// divider, one whose quench ratio reaches one makes a single pass, and any
// other hit makes two passes of the shared 64-step restoring divider. A mean
// report skips the divider when there are no events and uses it otherwise.
// All arithmetic runs through one 32 by 32 multiplier and that divider.
`default_nettype none

module birks_energy_estimator
	import bee_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [CfgW-1:0]    cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         req_type,
	input  wire logic [23:0]        plain_charge_sum,
	input  wire logic [23:0]        reference_energy,
	input  wire logic [19:0]        hit_charge,
	input  wire logic [15:0]        hit_length,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    result_kind,
	output logic signed [31:0]      energy_estimate,
	output logic [62:0]             squared_error,
	output logic [31:0]             events_seen
);

	cmd_t cmd;
	status_t status;

	// Sequencer.
	bee_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.status   (status),
		.cmd      (cmd)
	);

	// Arithmetic and state.
	bee_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.plain_charge_sum (plain_charge_sum),
		.reference_energy (reference_energy),
		.hit_charge       (hit_charge),
		.hit_length       (hit_length),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.result_kind      (result_kind),
		.energy_estimate  (energy_estimate),
		.squared_error    (squared_error),
		.events_seen      (events_seen)
	);

endmodule

`default_nettype wire

/* rtl/bee_datapath.sv */
`default_nettype none

module bee_datapath
	import bee_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output status_t                 status,
	input  wire logic               cfg_write,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [CfgW-1:0]    cfg_data,
	input  wire logic [23:0]        plain_charge_sum,
	input  wire logic [23:0]        reference_energy,
	input  wire logic [19:0]        hit_charge,
	input  wire logic [15:0]        hit_length,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    result_kind,
	output logic signed [31:0]      energy_estimate,
	output logic [62:0]             squared_error,
	output logic [31:0]             events_seen
);

	logic [CfgW-1:0] gain_q, quench_q, cap_q;
	logic [23:0] sum_q, ref_in_q;
	logic [19:0] dq_q;
	logic [15:0] dx_q;
	logic [AccW-1:0] acc_q;
	logic [23:0] ref_q;
	logic [63:0] err_sum_q;
	logic [31:0] cnt_q;
	logic [43:0] a_q;
	logic [63:0] prod_q;
	logic [DivW-1:0] dvd_q;
	logic [31:0] rem_q, dvs_q;
	logic [DivCntW-1:0] div_cnt_q;
	logic out_valid_q;

	logic [31:0] mul_a, mul_b;
	logic [32:0] rem_sh;
	logic div_ge;
	logic [24:0] den;
	logic [30:0] est, diff;
	logic [28:0] plain;
	logic [28:0] add_val;
	logic use_q;
	logic [AccW:0] acc_sum;
	logic [32:0] start_val;
	logic [64:0] err_sum_next;
	logic [31:0] cnt_inc;
	logic out_free;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			quench_q <= QUENCH_RESET;
			cap_q <= CAP_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_CHARGE_GAIN: gain_q <= cfg_data;
				CFG_QUENCH_FACTOR: quench_q <= cfg_data;
				CFG_ENERGY_CAP: cap_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Multiplier operand selection.
	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		unique case (cmd)
			CMD_MUL_SUM: begin
				mul_a = {8'd0, gain_q};
				mul_b = {8'd0, sum_q};
			end
			CMD_MUL_A: begin
				mul_a = {8'd0, gain_q};
				mul_b = {12'd0, dq_q};
			end
			CMD_MUL_B: begin
				mul_a = {8'd0, quench_q};
				mul_b = {12'd0, dq_q};
			end
			CMD_MUL_SQ: begin
				mul_a = {1'b0, diff};
				mul_b = {1'b0, diff};
			end
			default: ;
		endcase
	end

	// Restoring divider step and the Birks denominator.
	assign rem_sh = {rem_q, dvd_q[DivW-1]};
	assign div_ge = rem_sh >= {1'b0, dvs_q};
	assign den = 25'h100_0000 - {1'b0, dvd_q[23:0]};

	// Event estimate and its distance from the reference.
	always_comb begin
		if (acc_q > {9'd0, 31'h7FFF_FFFF}) begin
			est = 31'h7FFF_FFFF;
		end else begin
			est = acc_q[30:0];
		end
		if (est >= {7'd0, ref_q}) begin
			diff = est - {7'd0, ref_q};
		end else begin
			diff = {7'd0, ref_q} - est;
		end
	end

	// Hit energy selection and saturating accumulation.
	always_comb begin
		plain = 29'((45'(a_q) + 45'h8000) >> 16);
		use_q = (dvd_q != 64'd0) && (dvd_q < {40'd0, cap_q});
		if ((cmd == CMD_HIT_Q) && use_q) begin
			add_val = {5'd0, dvd_q[23:0]};
		end else begin
			add_val = plain;
		end
		acc_sum = {1'b0, acc_q} + {12'd0, add_val};
		start_val = 33'((49'(prod_q[47:0]) + 49'h8000) >> 16);
		err_sum_next = {1'b0, err_sum_q} + {3'd0, prod_q[61:0]};
		cnt_inc = (cnt_q == 32'hFFFF_FFFF) ? cnt_q : cnt_q + 32'd1;
	end

	assign out_free = !out_valid_q || out_ready;

	// Working registers. The product holds until the next multiply, so a
	// stalled event end still finds its squared error.
	always_ff @(posedge clk) begin
		if (cmd == CMD_LATCH) begin
			sum_q <= plain_charge_sum;
			ref_in_q <= reference_energy;
			dq_q <= hit_charge;
			dx_q <= hit_length;
		end
		if (cmd == CMD_MUL_B) begin
			a_q <= prod_q[43:0];
		end
		if (cmd == CMD_MUL_SUM || cmd == CMD_MUL_A || cmd == CMD_MUL_B
				|| cmd == CMD_MUL_SQ) begin
			prod_q <= mul_a * mul_b;
		end
		unique case (cmd)
			CMD_DIV_R: begin
				dvd_q <= {12'd0, prod_q[43:0], 8'd0};
				dvs_q <= {16'd0, dx_q};
				rem_q <= 32'd0;
			end
			CMD_DIV_Q: begin
				dvd_q <= {12'd0, a_q, 8'd0} + {40'd0, den[24:1]};
				dvs_q <= {7'd0, den};
				rem_q <= 32'd0;
			end
			CMD_DIV_MSE: begin
				dvd_q <= err_sum_q;
				dvs_q <= cnt_q;
				rem_q <= 32'd0;
			end
			CMD_DIV_STEP: begin
				dvd_q <= {dvd_q[DivW-2:0], div_ge};
				rem_q <= div_ge ? 32'(rem_sh - {1'b0, dvs_q}) : rem_sh[31:0];
			end
			default: ;
		endcase
	end

	// Divider step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd == CMD_DIV_R || cmd == CMD_DIV_Q || cmd == CMD_DIV_MSE) begin
			div_cnt_q <= '0;
		end else if (cmd == CMD_DIV_STEP) begin
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	// Event state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			ref_q <= '0;
			err_sum_q <= '0;
			cnt_q <= '0;
		end else begin
			unique case (cmd)
				CMD_START_WR: begin
					acc_q <= {7'd0, start_val};
					ref_q <= ref_in_q;
				end
				CMD_HIT_PLAIN, CMD_HIT_Q: begin
					acc_q <= acc_sum[AccW] ? {AccW{1'b1}} : acc_sum[AccW-1:0];
				end
				CMD_END_OUT: begin
					err_sum_q <= err_sum_next[64] ? 64'hFFFF_FFFF_FFFF_FFFF
						: err_sum_next[63:0];
					cnt_q <= cnt_inc;
				end
				default: ;
			endcase
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd == CMD_END_OUT || cmd == CMD_REPORT_OUT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_END_OUT) begin
			result_kind <= KIND_EVENT;
			energy_estimate <= signed'({1'b0, est});
			squared_error <= {1'b0, prod_q[61:0]};
			events_seen <= cnt_inc;
		end else if (cmd == CMD_REPORT_OUT) begin
			result_kind <= KIND_MEAN;
			energy_estimate <= '0;
			if (cnt_q == 32'd0) begin
				squared_error <= '0;
			end else if (dvd_q[63]) begin
				squared_error <= {63{1'b1}};
			end else begin
				squared_error <= dvd_q[62:0];
			end
			events_seen <= cnt_q;
		end
	end

	assign out_valid = out_valid_q;

	// Status back to the controller.
	assign status.dx_zero = (dx_q == 16'd0);
	assign status.div_last = (div_cnt_q == {DivCntW{1'b1}});
	assign status.r_big = (dvd_q[63:24] != 40'd0);
	assign status.cnt_zero = (cnt_q == 32'd0);
	assign status.out_free = out_free;

	// A result is only loaded when the output register can take it.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_END_OUT || cmd == CMD_REPORT_OUT) |-> out_free)
		else $error("result loaded over a waiting word");

	// Every division restarts its step count.
	a_div_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_DIV_R || cmd == CMD_DIV_Q || cmd == CMD_DIV_MSE) |=> (div_cnt_q == '0))
		else $error("divider count not cleared at start");

	// The corrected division runs only with a quench ratio below one.
	a_ratio_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_DIV_Q) |-> (dvd_q[63:24] == 40'd0))
		else $error("Birks division started with ratio at or above one");

endmodule

`default_nettype wire

/* rtl/bee_ctrl.sv */
`default_nettype none

module bee_ctrl
	import bee_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] req_type,
	input  wire status_t    status,
	output cmd_t            cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (req_type)
						REQ_START: state_d = S_ST_MUL;
						REQ_HIT: state_d = S_H_MULA;
						REQ_END: state_d = S_E_MUL;
						REQ_REPORT: state_d = S_R_CHK;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_ST_MUL: state_d = S_ST_WR;
			S_ST_WR: state_d = S_IDLE;
			S_H_MULA: state_d = S_H_MULB;
			S_H_MULB: state_d = S_H_CHK;
			S_H_CHK: state_d = status.dx_zero ? S_IDLE : S_H_DIVR;
			S_H_DIVR: if (status.div_last) state_d = S_H_CHKR;
			S_H_CHKR: state_d = status.r_big ? S_IDLE : S_H_DIVQ;
			S_H_DIVQ: if (status.div_last) state_d = S_H_ADD;
			S_H_ADD: state_d = S_IDLE;
			S_E_MUL: state_d = S_E_OUT;
			S_E_OUT: if (status.out_free) state_d = S_IDLE;
			S_R_CHK: state_d = status.cnt_zero ? S_R_OUT : S_R_DIV;
			S_R_DIV: if (status.div_last) state_d = S_R_OUT;
			S_R_OUT: if (status.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd = CMD_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd = CMD_LATCH;
			end
			S_ST_MUL: cmd = CMD_MUL_SUM;
			S_ST_WR: cmd = CMD_START_WR;
			S_H_MULA: cmd = CMD_MUL_A;
			S_H_MULB: cmd = CMD_MUL_B;
			S_H_CHK: cmd = status.dx_zero ? CMD_HIT_PLAIN : CMD_DIV_R;
			S_H_DIVR: cmd = CMD_DIV_STEP;
			S_H_CHKR: cmd = status.r_big ? CMD_HIT_PLAIN : CMD_DIV_Q;
			S_H_DIVQ: cmd = CMD_DIV_STEP;
			S_H_ADD: cmd = CMD_HIT_Q;
			S_E_MUL: cmd = CMD_MUL_SQ;
			S_E_OUT: if (status.out_free) cmd = CMD_END_OUT;
			S_R_CHK: if (!status.cnt_zero) cmd = CMD_DIV_MSE;
			S_R_DIV: cmd = CMD_DIV_STEP;
			S_R_OUT: if (status.out_free) cmd = CMD_REPORT_OUT;
			default: ;
		endcase
	end

endmodule

`default_nettype wire
